[sv/hv_precharge_sequencer_defines.svh]
// ---------------------------------------------------------------------------
// hv_precharge_sequencer_defines.svh
// Assertion macros for the HV precharge sequencer.
// ---------------------------------------------------------------------------
`ifndef HV_PRECHARGE_SEQUENCER_DEFINES_SVH
`define HV_PRECHARGE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked property on clk, disabled while rst_n is low.
`define HVP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hvp: assertion failed");
// Condition that must never be seen.
`define HVP_ASSERT_NEVER(lbl, expr) \
    `HVP_ASSERT(lbl, !(expr))
`else
`define HVP_ASSERT(lbl, prop)
`define HVP_ASSERT_NEVER(lbl, expr)
`endif

`endif

[sv/hvp_pkg.sv]
// ---------------------------------------------------------------------------
// hvp_pkg
// Shared types, codes and constants of the HV precharge sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package hvp_pkg;

    localparam int VOLT_BITS_DEFAULT = 10;

    localparam int TIME_W     = 32;
    localparam int DELAY_W    = 16;
    localparam int TIMEOUT_W  = 16;
    localparam int HOLD_W     = 10;
    localparam int WINDOW_W   = 8;
    localparam int MIN_HV_W   = 10;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE_DELAY = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_HOLD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_HV     = 3'd4;

    // reset values
    localparam logic [DELAY_W-1:0]   MODE_DELAY_RST = 16'd500;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 16'd10000;
    localparam logic [HOLD_W-1:0]    CLEAR_HOLD_RST = 10'd100;
    localparam logic [WINDOW_W-1:0]  WINDOW_RST     = 8'd20;
    localparam logic [MIN_HV_W-1:0]  MIN_HV_RST     = 10'd50;

    typedef enum logic [1:0] {
        MODE_UNSET = 2'd0,
        MODE_BOOST = 2'd1,
        MODE_BUCK  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [DELAY_W-1:0]   mode_delay;
        logic [TIMEOUT_W-1:0] timeout;
        logic [HOLD_W-1:0]    clear_hold;
        logic [WINDOW_W-1:0]  window;
        logic [MIN_HV_W-1:0]  min_hv;
    } cfg_t;

    typedef struct packed {
        mode_t mode;
        logic  enable;
        logic  precharged;
        logic  armed;
        logic  clearing;
        logic  clear_err;
    } ctrl_t;

    localparam ctrl_t CTRL_RST = '{
        mode:       MODE_UNSET,
        enable:     1'b0,
        precharged: 1'b0,
        armed:      1'b0,
        clearing:   1'b0,
        clear_err:  1'b0
    };

endpackage

`default_nettype wire

[sv/hvp_cfg_regs.sv]
// ---------------------------------------------------------------------------
// hvp_cfg_regs
// Configuration register file, write only.
// ---------------------------------------------------------------------------
`default_nettype none

module hvp_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [hvp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hvp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output hvp_pkg::cfg_t                        cfg
);

    hvp_pkg::cfg_t cfg_reg;
    hvp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                hvp_pkg::CFG_MODE_DELAY:
                    cfg_next.mode_delay = cfg_data[hvp_pkg::DELAY_W-1:0];
                hvp_pkg::CFG_TIMEOUT:
                    cfg_next.timeout = cfg_data[hvp_pkg::TIMEOUT_W-1:0];
                hvp_pkg::CFG_CLEAR_HOLD:
                    cfg_next.clear_hold = cfg_data[hvp_pkg::HOLD_W-1:0];
                hvp_pkg::CFG_WINDOW:
                    cfg_next.window = cfg_data[hvp_pkg::WINDOW_W-1:0];
                hvp_pkg::CFG_MIN_HV:
                    cfg_next.min_hv = cfg_data[hvp_pkg::MIN_HV_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_delay <= hvp_pkg::MODE_DELAY_RST;
            cfg_reg.timeout    <= hvp_pkg::TIMEOUT_RST;
            cfg_reg.clear_hold <= hvp_pkg::CLEAR_HOLD_RST;
            cfg_reg.window     <= hvp_pkg::WINDOW_RST;
            cfg_reg.min_hv     <= hvp_pkg::MIN_HV_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[sv/hvp_update.sv]
// ---------------------------------------------------------------------------
// hvp_update
// Next-state logic of one update call: boost precharge, clear hold, buck run, disarm.
// ---------------------------------------------------------------------------
`default_nettype none

module hvp_update #(
    parameter int VOLT_BITS = hvp_pkg::VOLT_BITS_DEFAULT
) (
    input  wire hvp_pkg::cfg_t                cfg,
    input  wire hvp_pkg::ctrl_t               ctrl,
    input  wire logic [hvp_pkg::TIME_W-1:0]   mode_time,
    input  wire logic [hvp_pkg::TIME_W-1:0]   clear_start,
    input  wire logic [VOLT_BITS-1:0]         target,
    input  wire logic                         arm,
    input  wire logic [hvp_pkg::TIME_W-1:0]   now_ms,
    input  wire logic [VOLT_BITS-1:0]         battery_volts,
    input  wire logic [VOLT_BITS-1:0]         hv_actual_volts,
    output hvp_pkg::ctrl_t                    ctrl_next,
    output logic [hvp_pkg::TIME_W-1:0]        mode_time_next,
    output logic [hvp_pkg::TIME_W-1:0]        clear_start_next,
    output logic [VOLT_BITS-1:0]              target_next
);

    // signed window compare width, room for battery + window
    localparam int CW = VOLT_BITS + 2;
    // min-voltage compare width
    localparam int MW = (VOLT_BITS > hvp_pkg::MIN_HV_W) ? VOLT_BITS : hvp_pkg::MIN_HV_W;

    logic signed [CW-1:0]       batt_s;
    logic signed [CW-1:0]       hv_s;
    logic signed [CW-1:0]       win_s;
    logic signed [CW-1:0]       lower_s;
    logic signed [CW-1:0]       upper_s;
    logic [MW-1:0]              hv_x;
    logic [MW-1:0]              min_x;
    logic                       in_window;
    logic                       boost_switch;
    logic                       buck_switch;
    logic [hvp_pkg::TIME_W-1:0] elapsed_boost;
    logic [hvp_pkg::TIME_W-1:0] elapsed_buck;
    logic [hvp_pkg::TIME_W-1:0] elapsed_hold;
    logic                       boost_wait_done;
    logic                       buck_wait_done;
    logic                       hold_done;
    logic                       timed_out;

    always_comb
    begin
        batt_s    = signed'(CW'(battery_volts));
        hv_s      = signed'(CW'(hv_actual_volts));
        win_s     = signed'(CW'(cfg.window));
        lower_s   = batt_s - win_s;
        upper_s   = batt_s + win_s;
        hv_x      = MW'(hv_actual_volts);
        min_x     = MW'(cfg.min_hv);
        in_window = (hv_s >= lower_s) && (hv_s <= upper_s) && (hv_x > min_x);
    end

    // A mode change restamps the mode time, so elapsed reads zero then.
    assign boost_switch  = (ctrl.mode != hvp_pkg::MODE_BOOST);
    assign buck_switch   = (ctrl.mode != hvp_pkg::MODE_BUCK);
    assign elapsed_boost = boost_switch ? '0 : (now_ms - mode_time);
    assign elapsed_buck  = buck_switch ? '0 : (now_ms - mode_time);
    assign elapsed_hold  = now_ms - clear_start;

    assign boost_wait_done = elapsed_boost >= hvp_pkg::TIME_W'(cfg.mode_delay);
    assign buck_wait_done  = elapsed_buck >= hvp_pkg::TIME_W'(cfg.mode_delay);
    assign hold_done       = elapsed_hold >= hvp_pkg::TIME_W'(cfg.clear_hold);
    assign timed_out       = elapsed_boost > hvp_pkg::TIME_W'(cfg.timeout);

    always_comb
    begin
        ctrl_next        = ctrl;
        mode_time_next   = mode_time;
        clear_start_next = clear_start;
        target_next      = target;

        if (arm)
        begin
            if (!ctrl.precharged)
            begin
                if (boost_switch)
                begin
                    ctrl_next.mode   = hvp_pkg::MODE_BOOST;
                    mode_time_next   = now_ms;
                    ctrl_next.enable = 1'b0;
                end
                if (boost_wait_done)
                begin
                    target_next      = battery_volts;
                    ctrl_next.enable = 1'b1;
                    if (in_window)
                    begin
                        if (!ctrl.clearing)
                        begin
                            ctrl_next.enable    = 1'b0;
                            ctrl_next.clear_err = 1'b1;
                            ctrl_next.clearing  = 1'b1;
                            clear_start_next    = now_ms;
                        end
                        else if (hold_done)
                        begin
                            ctrl_next.clear_err  = 1'b0;
                            ctrl_next.clearing   = 1'b0;
                            ctrl_next.precharged = 1'b1;
                        end
                    end
                    else if (timed_out)
                    begin
                        ctrl_next.enable = 1'b0;
                        mode_time_next   = now_ms;
                    end
                end
            end
            else
            begin
                ctrl_next.armed = 1'b1;
                if (buck_switch)
                begin
                    ctrl_next.mode   = hvp_pkg::MODE_BUCK;
                    mode_time_next   = now_ms;
                    ctrl_next.enable = 1'b0;
                end
                if (buck_wait_done)
                begin
                    ctrl_next.enable = 1'b1;
                end
            end
        end
        else
        begin
            // disarm: clear-error flag, mode, target and stamps are kept
            ctrl_next.armed      = 1'b0;
            ctrl_next.enable     = 1'b0;
            ctrl_next.precharged = 1'b0;
            ctrl_next.clearing   = 1'b0;
        end
    end

endmodule

`default_nettype wire

[sv/hv_precharge_sequencer.sv]
// ---------------------------------------------------------------------------
// hv_precharge_sequencer
// HV precharge and contactor sequencer for a DC/DC converter.
// ---------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   in       | in_valid / in_ready  | arm, now_ms, battery_volts,
//            |                      | hv_actual_volts
//   out      | out_valid / out_ready| converter_mode, converter_enable,
//            |                      | hv_target_volts, clear_error_req,
//            |                      | contactor_closed, battery_armed,
//            |                      | precharge_done
//   cfg      | cfg_we (no stall)    | cfg_index, cfg_data
//
// Flow: an item is held in the input register, then the update
//   logic writes the sequencer state, which doubles as the result register.
//   out_valid rises when that state is written; one item per cycle while
//   out_ready stays high.
// Throughput is set by the single update pass between the two registers.
// Stalls: with out_ready low the result holds and the input register keeps
//   one more item; in_ready then drops until the result is taken.
// Reset: configuration returns to its defaults, state to zero, both
//   valid flags clear. No clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

`include "hv_precharge_sequencer_defines.svh"

module hv_precharge_sequencer #(
    parameter int VOLT_BITS = hvp_pkg::VOLT_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [hvp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hvp_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            arm,
    input  wire logic [hvp_pkg::TIME_W-1:0]      now_ms,
    input  wire logic [VOLT_BITS-1:0]            battery_volts,
    input  wire logic [VOLT_BITS-1:0]            hv_actual_volts,
    // result items
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           converter_mode,
    output logic                                 converter_enable,
    output logic [VOLT_BITS-1:0]                 hv_target_volts,
    output logic                                 clear_error_req,
    output logic                                 contactor_closed,
    output logic                                 battery_armed,
    output logic                                 precharge_done
);

    hvp_pkg::cfg_t cfg;

    // input register
    logic                       in_valid_reg;
    logic                       arm_reg;
    logic [hvp_pkg::TIME_W-1:0] now_reg;
    logic [VOLT_BITS-1:0]       batt_reg;
    logic [VOLT_BITS-1:0]       hv_reg;

    // sequencer state, also the result register
    logic                       out_valid_reg;
    hvp_pkg::ctrl_t             ctrl_reg;
    logic [hvp_pkg::TIME_W-1:0] mode_time_reg;
    logic [hvp_pkg::TIME_W-1:0] clear_start_reg;
    logic [VOLT_BITS-1:0]       target_reg;

    hvp_pkg::ctrl_t             ctrl_next;
    logic [hvp_pkg::TIME_W-1:0] mode_time_next;
    logic [hvp_pkg::TIME_W-1:0] clear_start_next;
    logic [VOLT_BITS-1:0]       target_next;

    logic in_load;
    logic advance;

    hvp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The item in the input register moves on when the result slot is
    // empty or being emptied in the same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_load  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            arm_reg  <= arm;
            now_reg  <= now_ms;
            batt_reg <= battery_volts;
            hv_reg   <= hv_actual_volts;
        end
    end

    hvp_update #(
        .VOLT_BITS (VOLT_BITS)
    ) u_update (
        .cfg              (cfg),
        .ctrl             (ctrl_reg),
        .mode_time        (mode_time_reg),
        .clear_start      (clear_start_reg),
        .target           (target_reg),
        .arm              (arm_reg),
        .now_ms           (now_reg),
        .battery_volts    (batt_reg),
        .hv_actual_volts  (hv_reg),
        .ctrl_next        (ctrl_next),
        .mode_time_next   (mode_time_next),
        .clear_start_next (clear_start_next),
        .target_next      (target_next)
    );

    // State only moves when the result slot takes the new value, so the
    // shown result always equals the current state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            ctrl_reg        <= hvp_pkg::CTRL_RST;
            mode_time_reg   <= '0;
            clear_start_reg <= '0;
            target_reg      <= '0;
        end
        else if (advance)
        begin
            out_valid_reg   <= 1'b1;
            ctrl_reg        <= ctrl_next;
            mode_time_reg   <= mode_time_next;
            clear_start_reg <= clear_start_next;
            target_reg      <= target_next;
        end
        else if (out_ready)
        begin
            out_valid_reg   <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign converter_mode   = ctrl_reg.mode;
    assign converter_enable = ctrl_reg.enable;
    assign hv_target_volts  = target_reg;
    assign clear_error_req  = ctrl_reg.clear_err;
    assign contactor_closed = ctrl_reg.precharged;
    assign battery_armed    = ctrl_reg.armed;
    assign precharge_done   = ctrl_reg.precharged;

    // normal armed mode only after precharge
    `HVP_ASSERT_NEVER(a_armed_needs_precharge, ctrl_reg.armed && !ctrl_reg.precharged)
    // clear hold is finished before the contactor closes
    `HVP_ASSERT_NEVER(a_closed_no_clear,
        ctrl_reg.precharged && (ctrl_reg.clearing || ctrl_reg.clear_err))
    // clear hold only happens in the boost phase
    `HVP_ASSERT(a_clearing_boost, ctrl_reg.clearing |-> ctrl_reg.mode == hvp_pkg::MODE_BOOST)
    // converter never enabled before a mode was chosen
    `HVP_ASSERT_NEVER(a_enable_needs_mode, ctrl_reg.enable && ctrl_reg.mode == hvp_pkg::MODE_UNSET)
    // state is frozen while no item advances
    `HVP_ASSERT(a_state_hold,
        !advance |=> $stable(ctrl_reg) && $stable(mode_time_reg) && $stable(target_reg))

endmodule

`default_nettype wire
